// File: design/polygon_area_centroid_macros.svh
// Assertion macros shared by the polygon area and centroid design.
`ifndef POLYGON_AREA_CENTROID_MACROS_SVH
`define POLYGON_AREA_CENTROID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pac_pkg.sv
// Types and constants shared by the polygon area and centroid modules.
package pac_pkg;

   localparam int COORD_WIDTH       = 16;
   localparam int PROD_WIDTH        = 2 * COORD_WIDTH;
   localparam int CROSS_WIDTH       = PROD_WIDTH + 1;
   localparam int PAIR_WIDTH        = COORD_WIDTH + 1;
   localparam int TERM_WIDTH        = PAIR_WIDTH + CROSS_WIDTH;
   localparam int AREA_WIDTH        = 48;
   localparam int MOMENT_WIDTH      = 64;
   localparam int DEN_WIDTH         = AREA_WIDTH + 2;
   localparam int QUOT_WIDTH        = 16;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_INDEX_WIDTH = $clog2(QUEUE_DEPTH);

   localparam logic signed [QUOT_WIDTH-1:0] CENTROID_MAX   = 16'sh7FFF;
   localparam logic signed [QUOT_WIDTH-1:0] CENTROID_MIN   = 16'sh8000;
   localparam logic        [QUOT_WIDTH-1:0] QUOT_POS_LIMIT = 16'h7FFF;
   localparam logic        [QUOT_WIDTH-1:0] QUOT_NEG_LIMIT = 16'h8000;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_AREA = 2'd1,
      STATUS_LIMIT     = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic                          last_vertex;
   } req_word_type;

   typedef struct packed {
      logic signed [AREA_WIDTH-1:0] signed_area;
      logic signed [QUOT_WIDTH-1:0] centroid_x;
      logic signed [QUOT_WIDTH-1:0] centroid_y;
      status_type                   status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
   } point_type;

   typedef struct packed {
      logic      edge_valid;
      logic      close;
      logic      over_limit;
      point_type head_point;
      point_type tail_point;
   } edge_cmd_type;

   typedef struct packed {
      logic signed [AREA_WIDTH-1:0]   cross_sum;
      logic signed [MOMENT_WIDTH-1:0] moment_x_sum;
      logic signed [MOMENT_WIDTH-1:0] moment_y_sum;
      logic                           over_limit;
   } close_sums_type;

   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_SETUP,
      DIV_RANGE,
      DIV_SHIFT,
      DIV_FINISH,
      DIV_EMIT
   } div_state_type;

endpackage

// File: design/pac_front.sv
// Front end: accepts vertices, tracks the polygon and issues edge commands.
module pac_front #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pac_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output pac_pkg::edge_cmd_type cmd_word
);

   localparam int TallyWidth = $clog2(MAX_VERTICES + 2);
   localparam logic [TallyWidth-1:0] TallyLimit = TallyWidth'(MAX_VERTICES);
   localparam logic [TallyWidth-1:0] TallyOver  = TallyWidth'(MAX_VERTICES + 1);

   logic [TallyWidth-1:0] tally_ff, tally_in;
   pac_pkg::point_type    first_ff, first_in;
   pac_pkg::point_type    prev_ff, prev_in;
   pac_pkg::point_type    cur_point;
   logic                  pend_ff, pend_in;
   pac_pkg::edge_cmd_type pend_cmd_ff, pend_cmd_in;
   pac_pkg::edge_cmd_type edge_cmd;
   logic                  accept;
   logic                  under_limit;

   assign req_ready = !pend_ff && cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = pend_ff || (accept && edge_cmd.edge_valid);
   assign cmd_word  = pend_ff ? pend_cmd_ff : edge_cmd;

   always_comb begin
      cur_point   = '{x: req_word.pos_x, y: req_word.pos_y};
      under_limit = tally_ff < TallyLimit;
      edge_cmd    = '{edge_valid: under_limit && (tally_ff != '0), close: 1'b0,
                      over_limit: 1'b0, head_point: prev_ff, tail_point: cur_point};
      first_in    = first_ff;
      prev_in     = prev_ff;
      tally_in    = tally_ff;
      pend_in     = pend_ff;
      pend_cmd_in = pend_cmd_ff;
      if (pend_ff && cmd_ready) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         if (under_limit) begin
            if (tally_ff == '0) begin
               first_in = cur_point;
            end
            prev_in  = cur_point;
            tally_in = tally_ff + 1'b1;
         end else begin
            tally_in = TallyOver;
         end
         if (req_word.last_vertex) begin
            // The closing edge runs from this vertex back to the first one.
            pend_in     = 1'b1;
            pend_cmd_in = '{edge_valid: under_limit, close: 1'b1,
                            over_limit: !under_limit, head_point: cur_point,
                            tail_point: first_in};
            tally_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         tally_ff <= tally_in;
         pend_ff  <= pend_in;
      end
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      pend_cmd_ff <= pend_cmd_in;
   end

endmodule

// File: design/pac_fifo.sv
// Short queue of edge commands between the front end and the accumulator.
module pac_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pac_pkg::edge_cmd_type push_word,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pac_pkg::edge_cmd_type pop_word
);

   localparam int Depth      = pac_pkg::QUEUE_DEPTH;
   localparam int IndexWidth = pac_pkg::QUEUE_INDEX_WIDTH;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);
   localparam logic [IndexWidth-1:0] IndexLast = IndexWidth'(Depth - 1);

   pac_pkg::edge_cmd_type slot_ff [Depth];
   logic [IndexWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IndexWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != CountFull;
   assign pop_valid  = count_ff != '0;
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IndexLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IndexLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: design/pac_mac.sv
// Back end pipeline: edge cross products, moment terms and running sums.
module pac_mac (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  pac_pkg::edge_cmd_type   cmd_word,
   input  logic                    div_busy,
   output logic                    sums_valid,
   output pac_pkg::close_sums_type sums
);

   localparam int ProdWidth   = pac_pkg::PROD_WIDTH;
   localparam int CrossWidth  = pac_pkg::CROSS_WIDTH;
   localparam int PairWidth   = pac_pkg::PAIR_WIDTH;
   localparam int TermWidth   = pac_pkg::TERM_WIDTH;
   localparam int AreaWidth   = pac_pkg::AREA_WIDTH;
   localparam int MomentWidth = pac_pkg::MOMENT_WIDTH;

   logic pop;
   logic close_in_flight;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_close_ff, s1_close_in;
   logic                   s1_over_ff, s1_over_in;
   logic signed [ProdWidth-1:0] s1_prod_a_ff, s1_prod_a_in;
   logic signed [ProdWidth-1:0] s1_prod_b_ff, s1_prod_b_in;
   logic signed [PairWidth-1:0] s1_pair_x_ff, s1_pair_x_in;
   logic signed [PairWidth-1:0] s1_pair_y_ff, s1_pair_y_in;

   logic                    s2_valid_ff, s2_close_ff, s2_over_ff;
   logic signed [CrossWidth-1:0] s2_cross_ff, s2_cross_in;
   logic signed [PairWidth-1:0]  s2_pair_x_ff, s2_pair_y_ff;

   logic                    s3_valid_ff, s3_close_ff, s3_over_ff;
   logic signed [CrossWidth-1:0] s3_cross_ff;
   logic signed [TermWidth-1:0]  s3_term_x_ff, s3_term_x_in;
   logic signed [TermWidth-1:0]  s3_term_y_ff, s3_term_y_in;

   logic signed [AreaWidth-1:0]   acc_cross_ff, acc_cross_in, cross_next;
   logic signed [MomentWidth-1:0] acc_mx_ff, acc_mx_in, mx_next;
   logic signed [MomentWidth-1:0] acc_my_ff, acc_my_in, my_next;

   // A closing edge enters only when the divider will be free to take its sums.
   assign close_in_flight = (s1_valid_ff && s1_close_ff) || (s2_valid_ff && s2_close_ff) ||
                            (s3_valid_ff && s3_close_ff);
   assign cmd_ready = !(cmd_word.close && (close_in_flight || div_busy));
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      s1_valid_in  = pop;
      s1_close_in  = cmd_word.close;
      s1_over_in   = cmd_word.over_limit;
      s1_prod_a_in = '0;
      s1_prod_b_in = '0;
      s1_pair_x_in = '0;
      s1_pair_y_in = '0;
      if (cmd_word.edge_valid) begin
         s1_prod_a_in = ProdWidth'(cmd_word.head_point.x) * ProdWidth'(cmd_word.tail_point.y);
         s1_prod_b_in = ProdWidth'(cmd_word.tail_point.x) * ProdWidth'(cmd_word.head_point.y);
         s1_pair_x_in = PairWidth'(cmd_word.head_point.x) + PairWidth'(cmd_word.tail_point.x);
         s1_pair_y_in = PairWidth'(cmd_word.head_point.y) + PairWidth'(cmd_word.tail_point.y);
      end
      s2_cross_in  = CrossWidth'(s1_prod_a_ff) - CrossWidth'(s1_prod_b_ff);
      s3_term_x_in = TermWidth'(s2_pair_x_ff) * TermWidth'(s2_cross_ff);
      s3_term_y_in = TermWidth'(s2_pair_y_ff) * TermWidth'(s2_cross_ff);
      cross_next   = acc_cross_ff + AreaWidth'(s3_cross_ff);
      mx_next      = acc_mx_ff + MomentWidth'(s3_term_x_ff);
      my_next      = acc_my_ff + MomentWidth'(s3_term_y_ff);
      acc_cross_in = acc_cross_ff;
      acc_mx_in    = acc_mx_ff;
      acc_my_in    = acc_my_ff;
      if (s3_valid_ff) begin
         if (s3_close_ff) begin
            acc_cross_in = '0;
            acc_mx_in    = '0;
            acc_my_in    = '0;
         end else begin
            acc_cross_in = cross_next;
            acc_mx_in    = mx_next;
            acc_my_in    = my_next;
         end
      end
   end

   assign sums_valid = s3_valid_ff && s3_close_ff;
   assign sums       = '{cross_sum: cross_next, moment_x_sum: mx_next,
                         moment_y_sum: my_next, over_limit: s3_over_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         acc_cross_ff <= '0;
         acc_mx_ff    <= '0;
         acc_my_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         acc_cross_ff <= acc_cross_in;
         acc_mx_ff    <= acc_mx_in;
         acc_my_ff    <= acc_my_in;
      end
      s1_close_ff  <= s1_close_in;
      s1_over_ff   <= s1_over_in;
      s1_prod_a_ff <= s1_prod_a_in;
      s1_prod_b_ff <= s1_prod_b_in;
      s1_pair_x_ff <= s1_pair_x_in;
      s1_pair_y_ff <= s1_pair_y_in;
      s2_close_ff  <= s1_close_ff;
      s2_over_ff   <= s1_over_ff;
      s2_cross_ff  <= s2_cross_in;
      s2_pair_x_ff <= s1_pair_x_ff;
      s2_pair_y_ff <= s1_pair_y_ff;
      s3_close_ff  <= s2_close_ff;
      s3_over_ff   <= s2_over_ff;
      s3_cross_ff  <= s2_cross_ff;
      s3_term_x_ff <= s3_term_x_in;
      s3_term_y_ff <= s3_term_y_in;
   end

endmodule

// File: design/pac_div.sv
// Closing unit: shared restoring divider for the centroid and the result register.
module pac_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    sums_valid,
   input  pac_pkg::close_sums_type sums,
   output logic                    div_busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pac_pkg::rsp_word_type   rsp_word
);

   localparam int AreaWidth   = pac_pkg::AREA_WIDTH;
   localparam int MomentWidth = pac_pkg::MOMENT_WIDTH;
   localparam int DenWidth    = pac_pkg::DEN_WIDTH;
   localparam int QuotWidth   = pac_pkg::QUOT_WIDTH;
   localparam int RangeWidth  = DenWidth + QuotWidth;
   localparam int ShiftWidth  = RangeWidth - 1;
   localparam int StepWidth   = $clog2(QuotWidth);
   localparam logic [StepWidth-1:0] StepFirst = StepWidth'(QuotWidth - 1);

   function automatic logic [MomentWidth-1:0] moment_mag(
      input logic signed [MomentWidth-1:0] value
   );
      return value[MomentWidth-1] ? MomentWidth'(-value) : MomentWidth'(value);
   endfunction

   pac_pkg::div_state_type state_ff, state_in;

   logic signed [AreaWidth-1:0]   cross_ff, cross_in;
   logic signed [MomentWidth-1:0] mom_x_ff, mom_x_in;
   logic signed [MomentWidth-1:0] mom_y_ff, mom_y_in;
   logic                          over_ff, over_in;
   logic [DenWidth-1:0]           den_mag_ff, den_mag_in;
   pac_pkg::status_type           status_ff, status_in;
   logic [MomentWidth-1:0]        rem_ff, rem_in;
   logic [ShiftWidth-1:0]         shift_div_ff, shift_div_in;
   logic [QuotWidth-1:0]          quot_ff, quot_in;
   logic [StepWidth-1:0]          step_ff, step_in;
   logic                          neg_ff, neg_in;
   logic                          sel_y_ff, sel_y_in;
   logic signed [QuotWidth-1:0]   cx_ff, cx_in;
   logic signed [QuotWidth-1:0]   cy_ff, cy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pac_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic signed [DenWidth-1:0]    den_full;
   pac_pkg::status_type           setup_status;
   logic                          range_sat;
   logic                          load;
   logic [QuotWidth-1:0]          neg_quot;
   logic signed [QuotWidth-1:0]   centroid_val;

   assign den_full     = (DenWidth'(cross_ff) <<< 1) + DenWidth'(cross_ff);
   assign setup_status = over_ff ? pac_pkg::STATUS_LIMIT :
                         (cross_ff == '0) ? pac_pkg::STATUS_ZERO_AREA : pac_pkg::STATUS_OK;
   assign range_sat    = RangeWidth'(rem_ff) >= {den_mag_ff, {QuotWidth{1'b0}}};
   assign load         = !rsp_valid_ff || rsp_ready;
   assign neg_quot     = '0 - quot_ff;
   assign centroid_val = neg_ff ?
                         ((quot_ff > pac_pkg::QUOT_NEG_LIMIT) ? pac_pkg::CENTROID_MIN
                                                              : $signed(neg_quot)) :
                         ((quot_ff > pac_pkg::QUOT_POS_LIMIT) ? pac_pkg::CENTROID_MAX
                                                              : $signed(quot_ff));
   assign div_busy     = state_ff != pac_pkg::DIV_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pac_pkg::DIV_IDLE: begin
            if (sums_valid) begin
               state_in = pac_pkg::DIV_SETUP;
            end
         end
         pac_pkg::DIV_SETUP: begin
            state_in = (setup_status == pac_pkg::STATUS_OK) ? pac_pkg::DIV_RANGE
                                                            : pac_pkg::DIV_EMIT;
         end
         pac_pkg::DIV_RANGE: begin
            state_in = range_sat ? pac_pkg::DIV_FINISH : pac_pkg::DIV_SHIFT;
         end
         pac_pkg::DIV_SHIFT: begin
            if (step_ff == '0) begin
               state_in = pac_pkg::DIV_FINISH;
            end
         end
         pac_pkg::DIV_FINISH: begin
            state_in = sel_y_ff ? pac_pkg::DIV_EMIT : pac_pkg::DIV_RANGE;
         end
         pac_pkg::DIV_EMIT: begin
            if (load) begin
               state_in = pac_pkg::DIV_IDLE;
            end
         end
         default: state_in = pac_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      cross_in     = cross_ff;
      mom_x_in     = mom_x_ff;
      mom_y_in     = mom_y_ff;
      over_in      = over_ff;
      den_mag_in   = den_mag_ff;
      status_in    = status_ff;
      rem_in       = rem_ff;
      shift_div_in = shift_div_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      sel_y_in     = sel_y_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         pac_pkg::DIV_IDLE: begin
            if (sums_valid) begin
               cross_in = sums.cross_sum;
               mom_x_in = sums.moment_x_sum;
               mom_y_in = sums.moment_y_sum;
               over_in  = sums.over_limit;
            end
         end
         pac_pkg::DIV_SETUP: begin
            den_mag_in = den_full[DenWidth-1] ? DenWidth'(-den_full) : DenWidth'(den_full);
            status_in  = setup_status;
            cx_in      = '0;
            cy_in      = '0;
            sel_y_in   = 1'b0;
            rem_in     = moment_mag(mom_x_ff);
            neg_in     = mom_x_ff[MomentWidth-1] ^ cross_ff[AreaWidth-1];
         end
         pac_pkg::DIV_RANGE: begin
            // A quotient of 2^16 or more saturates either way.
            if (range_sat) begin
               quot_in = '1;
            end else begin
               quot_in      = '0;
               step_in      = StepFirst;
               shift_div_in = {den_mag_ff, {(QuotWidth - 1){1'b0}}};
            end
         end
         pac_pkg::DIV_SHIFT: begin
            if (ShiftWidth'(rem_ff) >= shift_div_ff) begin
               rem_in  = rem_ff - MomentWidth'(shift_div_ff);
               quot_in = {quot_ff[QuotWidth-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[QuotWidth-2:0], 1'b0};
            end
            shift_div_in = shift_div_ff >> 1;
            step_in      = step_ff - 1'b1;
         end
         pac_pkg::DIV_FINISH: begin
            if (sel_y_ff) begin
               cy_in = centroid_val;
            end else begin
               cx_in    = centroid_val;
               sel_y_in = 1'b1;
               rem_in   = moment_mag(mom_y_ff);
               neg_in   = mom_y_ff[MomentWidth-1] ^ cross_ff[AreaWidth-1];
            end
         end
         pac_pkg::DIV_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{
                  signed_area: (status_ff == pac_pkg::STATUS_LIMIT) ? '0 : cross_ff,
                  centroid_x:  cx_ff,
                  centroid_y:  cy_ff,
                  status:      status_ff
               };
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pac_pkg::DIV_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cross_ff     <= cross_in;
      mom_x_ff     <= mom_x_in;
      mom_y_ff     <= mom_y_in;
      over_ff      <= over_in;
      den_mag_ff   <= den_mag_in;
      status_ff    <= status_in;
      rem_ff       <= rem_in;
      shift_div_ff <= shift_div_in;
      quot_ff      <= quot_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      sel_y_ff     <= sel_y_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule

// File: design/polygon_area_centroid.sv
// Streaming shoelace polygon area and centroid, one vertex word per cycle unless stalled.
// Vertices stream in one per cycle while req_ready is high: the front end
// tracks the first and previous vertex and queues an edge command for each
// vertex after the first up to the vertex limit, and a four-stage
// multiply-accumulate pipeline adds each edge to the cross and moment sums.
// The vertex marked last also queues the closing edge back to the first
// vertex, and input waits while that edge is pending. The closing sums then
// pass to a single restoring divider that produces one quotient bit per
// cycle, x first and then y. A saturated quotient, a zero area or an
// exceeded vertex limit skips bit steps. A later polygon's vertices keep
// streaming while the divider works; only its own last vertex waits for
// the divider to be free.
`include "polygon_area_centroid_macros.svh"

module polygon_area_centroid #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pac_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pac_pkg::rsp_word_type rsp_word
);

   logic                    cmd_valid;
   logic                    cmd_ready;
   pac_pkg::edge_cmd_type   cmd_word;
   logic                    head_valid;
   logic                    head_ready;
   pac_pkg::edge_cmd_type   head_word;
   logic                    div_busy;
   logic                    sums_valid;
   pac_pkg::close_sums_type sums;

   pac_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_word  (cmd_word)
   );

   pac_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (cmd_ready),
      .push_word  (cmd_word),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_word   (head_word)
   );

   pac_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd_ready  (head_ready),
      .cmd_word   (head_word),
      .div_busy   (div_busy),
      .sums_valid (sums_valid),
      .sums       (sums)
   );

   pac_div u_div (
      .clock      (clock),
      .reset      (reset),
      .sums_valid (sums_valid),
      .sums       (sums),
      .div_busy   (div_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   `PAC_ASSERT_SAME(a_close_into_idle_div, clock, reset,
      sums_valid, !div_busy,
      "Closing sums arrived while the divider was busy.")
   `PAC_ASSERT_NEXT(a_last_blocks_input, clock, reset,
      req_valid && req_ready && req_word.last_vertex, !req_ready,
      "Input taken while a closing edge was pending.")
   `PAC_ASSERT_SAME(a_ok_has_area, clock, reset,
      rsp_valid && rsp_word.status == pac_pkg::STATUS_OK, rsp_word.signed_area != '0,
      "Result word marked ok with zero area.")
   `PAC_ASSERT_SAME(a_fault_zero_centroid, clock, reset,
      rsp_valid && rsp_word.status != pac_pkg::STATUS_OK,
      rsp_word.centroid_x == '0 && rsp_word.centroid_y == '0,
      "Result word with bad status carries a centroid.")

endmodule
